/* hdl/i2cm_pkg.sv */
package i2cm_pkg;

    // Largest data length honored per transaction
    localparam int unsigned C_MAX_BYTES = 255;

    // Command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Ticks per phase after reset
    localparam logic [15:0] C_PHASE_TICKS_RST = 16'd5;

    // Bus phases
    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_START_SETUP = 5'd1,
        PH_START_HOLD  = 5'd2,
        PH_ADDR_LOW    = 5'd3,
        PH_ADDR_HIGH   = 5'd4,
        PH_AACK_LOW    = 5'd5,
        PH_AACK_HIGH   = 5'd6,
        PH_TX_LOW      = 5'd7,
        PH_TX_HIGH     = 5'd8,
        PH_TACK_LOW    = 5'd9,
        PH_TACK_HIGH   = 5'd10,
        PH_RX_LOW      = 5'd11,
        PH_RX_HIGH     = 5'd12,
        PH_RACK_LOW    = 5'd13,
        PH_RACK_HIGH   = 5'd14,
        PH_STOP_LOW    = 5'd15,
        PH_STOP_SETUP  = 5'd16,
        PH_STOP_HOLD   = 5'd17
    } t_phase;

    // One tick as seen on the input port
    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] target_addr;
        logic [7:0] byte_count;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_tick_in;

    // Classified tick, as held in the queue
    typedef struct packed {
        logic       start;
        logic       is_read;
        logic [6:0] target_addr;
        logic [7:0] count;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_job;

    // One result word
    typedef struct packed {
        logic       scl_level;
        logic       scl_drive;
        logic       sda_level;
        logic       sda_drive;
        logic       tx_take;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [7:0] bytes_moved;
    } t_result;

endpackage

/* hdl/i2cm_front.sv */
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic     i_valid,
    input  t_tick_in i_word,
    output logic     o_push,
    output t_job     o_job
);

    localparam logic [7:0] MaxCnt = (C_MAX_BYTES > 255) ? 8'd255 : C_MAX_BYTES[7:0];

    logic [7:0] sat_cnt;

    always_comb begin
        sat_cnt = (i_word.byte_count > MaxCnt) ? MaxCnt : i_word.byte_count;
        o_job.start       = (i_word.cmd == CMD_WRITE) || (i_word.cmd == CMD_READ);
        o_job.is_read     = (i_word.cmd == CMD_READ);
        o_job.target_addr = i_word.target_addr;
        // zero-length read still moves one byte
        o_job.count       = ((i_word.cmd == CMD_READ) && (sat_cnt == 8'd0)) ? 8'd1 : sat_cnt;
        o_job.tx_byte     = i_word.tx_byte;
        o_job.sda_in      = i_word.sda_in;
        o_push            = i_valid;
    end

endmodule

/* hdl/i2cm_queue.sv */
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PtrW:0]   r_count,  n_count;
    logic            wr_en, rd_en;

    assign o_full  = (r_count == (PtrW+1)'(Depth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* hdl/i2cm_engine.sv */
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_word
);

    // drive nibble: scl_level, scl_drive, sda_level, sda_drive
    localparam logic [3:0] DrvReleased = 4'hA;

    function automatic logic [3:0] drive_of(input t_phase ph, input logic msb,
                                            input logic last);
        logic [3:0] d;
        case (ph)
            PH_START_SETUP:            d = 4'hF;
            PH_START_HOLD:             d = 4'hD;
            PH_ADDR_LOW, PH_TX_LOW:    d = {3'b010, 1'b1} | {2'b00, msb, 1'b0};
            PH_ADDR_HIGH, PH_TX_HIGH:  d = 4'hD | {2'b00, msb, 1'b0};
            PH_AACK_LOW, PH_TACK_LOW,
            PH_RX_LOW:                 d = 4'h6;
            PH_AACK_HIGH, PH_TACK_HIGH,
            PH_RX_HIGH:                d = 4'hE;
            PH_RACK_LOW:               d = 4'h5 | {2'b00, last, 1'b0};
            PH_RACK_HIGH:              d = 4'hD | {2'b00, last, 1'b0};
            PH_STOP_LOW:               d = 4'h5;
            PH_STOP_SETUP:             d = 4'hD;
            PH_STOP_HOLD:              d = 4'hF;
            default:                   d = DrvReleased;
        endcase
        return d;
    endfunction

    logic [15:0] r_ticks;
    t_phase      r_phase,  n_phase;
    logic [15:0] r_timer,  n_timer;
    logic [3:0]  r_bit,    n_bit;
    logic [7:0]  r_shift,  n_shift;
    logic [7:0]  r_rem,    n_rem;
    logic [7:0]  r_moved,  n_moved;
    logic        r_is_read, n_is_read;
    logic        r_nack,   n_nack;
    logic [3:0]  r_line,   n_line;
    logic        r_out_valid;
    t_result     r_out,    n_out;

    logic [15:0] pt;
    logic [16:0] timer_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  rem_dec;
    logic [7:0]  rx_shift;

    assign o_pop       = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_rem     = r_rem;
        n_moved   = r_moved;
        n_is_read = r_is_read;
        n_nack    = r_nack;
        n_out     = '0;

        pt        = (r_ticks == 16'd0) ? 16'd1 : r_ticks;
        timer_inc = {1'b0, r_timer} + 17'd1;
        bit_inc   = r_bit + 4'd1;
        rem_dec   = r_rem - 8'd1;
        rx_shift  = {r_shift[6:0], i_job.sda_in};

        if (r_phase == PH_IDLE) begin
            if (i_job.start) begin
                n_is_read = i_job.is_read;
                n_rem     = i_job.count;
                n_shift   = {i_job.target_addr, i_job.is_read};
                n_bit     = '0;
                n_timer   = '0;
                n_moved   = '0;
                n_nack    = 1'b0;
                n_phase   = PH_START_SETUP;
            end
        end else begin
            n_timer = timer_inc[15:0];
            if (timer_inc >= {1'b0, pt}) begin
                n_timer = '0;
                case (r_phase)
                    PH_START_SETUP: n_phase = PH_START_HOLD;
                    PH_START_HOLD: begin
                        n_phase = PH_ADDR_LOW;
                        n_bit   = '0;
                    end
                    PH_ADDR_LOW:    n_phase = PH_ADDR_HIGH;
                    PH_TX_LOW:      n_phase = PH_TX_HIGH;
                    PH_ADDR_HIGH, PH_TX_HIGH: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        if (bit_inc >= 4'd8) begin
                            n_bit   = '0;
                            n_phase = (r_phase == PH_ADDR_HIGH) ? PH_AACK_LOW : PH_TACK_LOW;
                        end else begin
                            n_bit   = bit_inc;
                            n_phase = (r_phase == PH_ADDR_HIGH) ? PH_ADDR_LOW : PH_TX_LOW;
                        end
                    end
                    PH_AACK_LOW:    n_phase = PH_AACK_HIGH;
                    PH_TACK_LOW:    n_phase = PH_TACK_HIGH;
                    PH_AACK_HIGH, PH_TACK_HIGH: begin
                        if (i_job.sda_in) begin
                            // target did not acknowledge
                            n_nack  = 1'b1;
                            n_phase = PH_STOP_LOW;
                        end else begin
                            if (r_phase == PH_TACK_HIGH) begin
                                n_moved = r_moved + 8'd1;
                                n_rem   = rem_dec;
                            end
                            n_bit = '0;
                            if (n_rem == 8'd0) begin
                                n_phase = PH_STOP_LOW;
                            end else if (r_is_read) begin
                                n_phase = PH_RX_LOW;
                            end else begin
                                n_out.tx_take = 1'b1;
                                n_shift       = i_job.tx_byte;
                                n_phase       = PH_TX_LOW;
                            end
                        end
                    end
                    PH_RX_LOW:      n_phase = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        n_shift = rx_shift;
                        if (bit_inc >= 4'd8) begin
                            n_bit          = '0;
                            n_rem          = rem_dec;
                            n_moved        = r_moved + 8'd1;
                            n_out.rx_valid = 1'b1;
                            n_out.rx_byte  = rx_shift;
                            n_out.rx_last  = (rem_dec == 8'd0);
                            n_phase        = PH_RACK_LOW;
                        end else begin
                            n_bit   = bit_inc;
                            n_phase = PH_RX_LOW;
                        end
                    end
                    PH_RACK_LOW:    n_phase = PH_RACK_HIGH;
                    PH_RACK_HIGH:   n_phase = (r_rem == 8'd0) ? PH_STOP_LOW : PH_RX_LOW;
                    PH_STOP_LOW:    n_phase = PH_STOP_SETUP;
                    PH_STOP_SETUP: begin
                        n_phase = PH_STOP_HOLD;
                        n_bit   = '0;
                    end
                    PH_STOP_HOLD: begin
                        // stop hold spans ten phases
                        if (bit_inc >= 4'd10) begin
                            n_bit          = '0;
                            n_phase        = PH_IDLE;
                            n_out.done_res = 1'b1;
                            n_out.status   = r_nack;
                        end else begin
                            n_bit = bit_inc;
                        end
                    end
                    default:        n_phase = PH_IDLE;
                endcase
            end
        end

        n_line            = drive_of(n_phase, n_shift[7], n_rem == 8'd0);
        n_out.scl_level   = r_line[3];
        n_out.scl_drive   = r_line[2];
        n_out.sda_level   = r_line[1];
        n_out.sda_drive   = r_line[0];
        n_out.busy_res    = (n_phase != PH_IDLE);
        n_out.bytes_moved = n_moved;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= C_PHASE_TICKS_RST;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_rem       <= '0;
            r_moved     <= '0;
            r_is_read   <= 1'b0;
            r_nack      <= 1'b0;
            r_line      <= DrvReleased;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ticks <= i_cfg_data;
            end
            if (o_pop) begin
                r_phase   <= n_phase;
                r_timer   <= n_timer;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_rem     <= n_rem;
                r_moved   <= n_moved;
                r_is_read <= n_is_read;
                r_nack    <= n_nack;
                r_line    <= n_line;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

/* hdl/i2c_master_transaction_unit.sv */
// A tick word is written into the queue; the bus engine pops it and registers its result word.
// Throughput: one tick word per cycle while the queue has room; the bus engine retires one
//   queued word per cycle while its output register is empty or not stalled.
// A 4-deep queue between the front decoder and the engine absorbs output stalls.
// Reset (synchronous, active low): engine idle, both bus lines released, phase_ticks = 5,
//   queue and output register empty.
module i2c_master_transaction_unit
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // tick words in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_tick_in    i_in_word,

    // result words out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_word,

    // phase_ticks register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // Front: classifies each tick (command decode, length saturation,
    // zero-length read promoted to one byte).
    logic q_push;
    t_job front_job;

    // Queue to engine
    logic q_full;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    i2cm_front u_front (
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    // Input side stalls only when the queue is full.
    assign o_in_stall = q_full;

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // Config writes land directly; send them only while the block is idle; the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    // Back: the per-tick bus engine. Pops a word whenever its output
    // register is empty or being drained this cycle.
    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

/* test/i2cm_result_checker.sv */
`timescale 1ns / 1ps

// Watches the tick, result and phase_ticks channels, runs its own copy of the
// bus engine on every accepted tick word and compares each result word.
module i2cm_result_checker
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_tick_in    i_in_word,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_result     i_out_word,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,

    output int          o_mismatches,
    output int          o_pending_words,
    output logic        o_engine_idle,   // engine idle after all accepted ticks
    output logic        o_cmd_ignored,   // a command on the tick after next is ignored
    output logic        o_ack_slot       // engine sits in an address or data ACK slot
);

    // line drive words: scl_level, scl_drive, sda_level, sda_drive
    localparam logic [3:0] DRV_RELEASED   = 4'b1010;
    localparam logic [3:0] DRV_BOTH_HIGH  = 4'b1111;
    localparam logic [3:0] DRV_SDA_LOW    = 4'b1101;
    localparam logic [3:0] DRV_BOTH_LOW   = 4'b0101;
    localparam logic [3:0] DRV_LISTEN_LOW = 4'b0110;
    localparam logic [3:0] DRV_LISTEN_HI  = 4'b1110;

    t_phase      bus_phase;
    int unsigned phase_count;
    int unsigned bit_count;
    logic [7:0]  shift_q;
    logic [7:0]  left_q;
    logic [7:0]  moved_q;
    logic        rd_q;
    logic        nacked_q;
    logic [3:0]  drive_q;
    logic [15:0] ticks_per_phase;

    t_result     bus_results_q[$];
    t_result     want_word;
    int          mismatch_total;

    function automatic logic [3:0] drive_for(t_phase ph);
        case (ph)
            PH_START_SETUP, PH_STOP_HOLD:           return DRV_BOTH_HIGH;
            PH_START_HOLD, PH_STOP_SETUP:           return DRV_SDA_LOW;
            PH_ADDR_LOW, PH_TX_LOW:                 return {2'b01, shift_q[7], 1'b1};
            PH_ADDR_HIGH, PH_TX_HIGH:               return {2'b11, shift_q[7], 1'b1};
            PH_AACK_LOW, PH_TACK_LOW, PH_RX_LOW:    return DRV_LISTEN_LOW;
            PH_AACK_HIGH, PH_TACK_HIGH, PH_RX_HIGH: return DRV_LISTEN_HI;
            // master ACKs with SDA low, NACKs the final byte with SDA high
            PH_RACK_LOW:                            return {2'b01, left_q == 8'd0, 1'b1};
            PH_RACK_HIGH:                           return {2'b11, left_q == 8'd0, 1'b1};
            PH_STOP_LOW:                            return DRV_BOTH_LOW;
            default:                                return DRV_RELEASED;
        endcase
    endfunction

    // One tick of the bus engine; the line drive reported is the one set up last tick.
    function automatic t_result advance_bus_engine(t_tick_in tk);
        t_result     r;
        int unsigned period;
        logic [3:0]  prev_drive;
        r          = '0;
        period     = (ticks_per_phase == 16'd0) ? 1 : ticks_per_phase;
        prev_drive = drive_q;
        if (bus_phase == PH_IDLE) begin
            if (tk.cmd == CMD_WRITE || tk.cmd == CMD_READ) begin
                rd_q        = (tk.cmd == CMD_READ);
                left_q      = (rd_q && tk.byte_count == 8'd0) ? 8'd1 : tk.byte_count;
                shift_q     = {tk.target_addr, rd_q};
                bit_count   = 0;
                phase_count = 0;
                moved_q     = '0;
                nacked_q    = 1'b0;
                bus_phase   = PH_START_SETUP;
            end
        end else begin
            phase_count++;
            if (phase_count >= period) begin
                phase_count = 0;
                case (bus_phase)
                    PH_START_SETUP: bus_phase = PH_START_HOLD;
                    PH_START_HOLD: begin
                        bus_phase = PH_ADDR_LOW;
                        bit_count = 0;
                    end
                    PH_ADDR_LOW: bus_phase = PH_ADDR_HIGH;
                    PH_TX_LOW:   bus_phase = PH_TX_HIGH;
                    PH_ADDR_HIGH, PH_TX_HIGH: begin
                        shift_q = {shift_q[6:0], 1'b0};
                        bit_count++;
                        if (bit_count >= 8) begin
                            bit_count = 0;
                            if (bus_phase == PH_ADDR_HIGH) bus_phase = PH_AACK_LOW;
                            else bus_phase = PH_TACK_LOW;
                        end else if (bus_phase == PH_ADDR_HIGH) begin
                            bus_phase = PH_ADDR_LOW;
                        end else begin
                            bus_phase = PH_TX_LOW;
                        end
                    end
                    PH_AACK_LOW: bus_phase = PH_AACK_HIGH;
                    PH_TACK_LOW: bus_phase = PH_TACK_HIGH;
                    PH_AACK_HIGH, PH_TACK_HIGH: begin
                        if (tk.sda_in) begin
                            nacked_q  = 1'b1;
                            bus_phase = PH_STOP_LOW;
                        end else begin
                            if (bus_phase == PH_TACK_HIGH) begin
                                moved_q = moved_q + 8'd1;
                                left_q  = left_q - 8'd1;
                            end
                            bit_count = 0;
                            if (left_q == 8'd0) begin
                                bus_phase = PH_STOP_LOW;
                            end else if (rd_q) begin
                                bus_phase = PH_RX_LOW;
                            end else begin
                                r.tx_take = 1'b1;
                                shift_q   = tk.tx_byte;
                                bus_phase = PH_TX_LOW;
                            end
                        end
                    end
                    PH_RX_LOW: bus_phase = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        shift_q = {shift_q[6:0], tk.sda_in};
                        bit_count++;
                        if (bit_count >= 8) begin
                            bit_count  = 0;
                            left_q     = left_q - 8'd1;
                            moved_q    = moved_q + 8'd1;
                            r.rx_valid = 1'b1;
                            r.rx_byte  = shift_q;
                            r.rx_last  = (left_q == 8'd0);
                            bus_phase  = PH_RACK_LOW;
                        end else begin
                            bus_phase = PH_RX_LOW;
                        end
                    end
                    PH_RACK_LOW: bus_phase = PH_RACK_HIGH;
                    PH_RACK_HIGH: begin
                        if (left_q == 8'd0) bus_phase = PH_STOP_LOW;
                        else bus_phase = PH_RX_LOW;
                    end
                    PH_STOP_LOW: bus_phase = PH_STOP_SETUP;
                    PH_STOP_SETUP: begin
                        bus_phase = PH_STOP_HOLD;
                        bit_count = 0;
                    end
                    PH_STOP_HOLD: begin
                        bit_count++;
                        if (bit_count >= 10) begin
                            bit_count  = 0;
                            bus_phase  = PH_IDLE;
                            r.done_res = 1'b1;
                            r.status   = nacked_q;
                        end
                    end
                    default: bus_phase = PH_IDLE;
                endcase
            end
        end
        drive_q       = drive_for(bus_phase);
        r.scl_level   = prev_drive[3];
        r.scl_drive   = prev_drive[2];
        r.sda_level   = prev_drive[1];
        r.sda_drive   = prev_drive[0];
        r.busy_res    = (bus_phase != PH_IDLE);
        r.bytes_moved = moved_q;
        return r;
    endfunction

    task automatic note_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: %s differs, got %0h, expected %0h", $time, what, got, want);
        mismatch_total++;
    endtask

    task automatic compare_field(string what, int unsigned got, int unsigned want);
        if (got != want)
            note_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bus_phase       = PH_IDLE;
            phase_count     = 0;
            bit_count       = 0;
            shift_q         = '0;
            left_q          = '0;
            moved_q         = '0;
            rd_q            = 1'b0;
            nacked_q        = 1'b0;
            drive_q         = DRV_RELEASED;
            ticks_per_phase = C_PHASE_TICKS_RST;
            mismatch_total  = 0;
            bus_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                ticks_per_phase = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (bus_results_q.size() == 0) begin
                    note_mismatch("unexpected result word", 32'(i_out_word), 0);
                end else begin
                    want_word = bus_results_q.pop_front();
                    compare_field("scl_level", i_out_word.scl_level, want_word.scl_level);
                    compare_field("scl_drive", i_out_word.scl_drive, want_word.scl_drive);
                    compare_field("sda_level", i_out_word.sda_level, want_word.sda_level);
                    compare_field("sda_drive", i_out_word.sda_drive, want_word.sda_drive);
                    compare_field("tx_take", i_out_word.tx_take, want_word.tx_take);
                    compare_field("rx_valid", i_out_word.rx_valid, want_word.rx_valid);
                    compare_field("rx_byte", i_out_word.rx_byte, want_word.rx_byte);
                    compare_field("rx_last", i_out_word.rx_last, want_word.rx_last);
                    compare_field("busy_res", i_out_word.busy_res, want_word.busy_res);
                    compare_field("done_res", i_out_word.done_res, want_word.done_res);
                    compare_field("status", i_out_word.status, want_word.status);
                    compare_field("bytes_moved", i_out_word.bytes_moved,
                                  want_word.bytes_moved);
                end
            end
            if (i_in_valid && !i_in_stall)
                bus_results_q.push_back(advance_bus_engine(i_in_word));
        end
        o_mismatches    <= mismatch_total;
        o_pending_words <= bus_results_q.size();
        o_engine_idle   <= (bus_phase == PH_IDLE);
        o_cmd_ignored   <= (bus_phase != PH_IDLE) && (bus_phase != PH_STOP_HOLD);
        o_ack_slot      <= (bus_phase == PH_AACK_LOW) || (bus_phase == PH_AACK_HIGH) ||
                           (bus_phase == PH_TACK_LOW) || (bus_phase == PH_TACK_HIGH);
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the I2C master transaction unit. Every tick word is one
// bus timing tick; the checker beside the DUT predicts and compares each result word.
module tb_top;
    import i2cm_pkg::*;

    // cmd value 3 has no meaning and must be treated as none
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 34;    // chance of a gap / stall per cycle
    localparam int HOLD_CYCLES    = 48;    // output hold-off, well past the 4-deep queue
    localparam int ENGINE_SETTLE  = 6;     // cycles past the last word before a reg write
    localparam int END_SETTLE     = 10;
    localparam int WATCHDOG_LIMIT = 1500;  // cycles with no word moving on any channel

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_tick_in    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_result     o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    int          mismatches;
    int          pending_words;
    logic        engine_idle;
    logic        cmd_ignored;
    logic        ack_slot;

    // shared with the stall process, written with NBAs only
    logic        calm;
    int          hold_seq;

    int          hold_seen;
    int          hold_left;
    int          quiet_cycles;
    int          ticks_sent;
    int          nack_pct;      // chance the target NACKs an ACK slot

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    i2c_master_transaction_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    i2cm_result_checker i_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_word       (i_in_word),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_word      (o_out_word),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending_words (pending_words),
        .o_engine_idle   (engine_idle),
        .o_cmd_ignored   (cmd_ignored),
        .o_ack_slot      (ack_slot)
    );

    // Result side: random stalls, none while calm, and a long hold-off each time
    // the stimulus bumps hold_seq.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen   <= 0;
            hold_left   <= 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: nothing moving for too long means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one tick word and wait for it to be taken. The checker's hints lag the
    // engine by at most one tick, so the ACK-slot hint (covering the low and the high
    // phase of the slot) still marks every tick on which an ACK is sampled.
    task automatic send_tick(logic [1:0] cmd, logic [6:0] addr, logic [7:0] count);
        t_tick_in w;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        w.cmd         = cmd;
        w.target_addr = addr;
        w.byte_count  = count;
        w.tx_byte     = 8'($urandom_range(255));
        w.sda_in      = ack_slot ? ($urandom_range(99) < nack_pct) : 1'($urandom_range(1));
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent++;
    endtask

    // Start a transaction, then keep ticking until the engine is idle again.
    // With noise on, some filler ticks carry commands the busy engine must drop.
    task automatic run_xfer(logic [1:0] cmd, logic [6:0] addr, logic [7:0] count,
                            int nackp, bit noise);
        logic [1:0] fill_cmd;
        nack_pct = nackp;
        send_tick(cmd, addr, count);
        do begin
            fill_cmd = CMD_NONE;
            if (noise && cmd_ignored && $urandom_range(9) == 0)
                fill_cmd = 2'($urandom_range(3));
            send_tick(fill_cmd, 7'($urandom_range(127)), 8'($urandom_range(255)));
        end while (!engine_idle);
    endtask

    // Finish any transaction, let every result word out, then write phase_ticks.
    task automatic write_phase_ticks(logic [15:0] value);
        do send_tick(CMD_NONE, 7'($urandom_range(127)), 8'($urandom_range(255)));
        while (!engine_idle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (ENGINE_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed transactions with short lengths; long ones get an
    // address NACK so they stay cheap. Runs until about budget more ticks went out.
    task automatic random_xfers(int budget);
        int         pick;
        logic [1:0] cmd;
        logic [7:0] count;
        int         nackp;
        int         stop_at;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at) begin
            pick = $urandom_range(19);
            if (pick == 0) cmd = CMD_UNUSED;
            else if (pick == 1) cmd = CMD_NONE;
            else if (pick < 11) cmd = CMD_WRITE;
            else cmd = CMD_READ;
            pick = $urandom_range(99);
            if (pick < 70) count = 8'($urandom_range(3));
            else if (pick < 95) count = 8'($urandom_range(12, 4));
            else count = 8'($urandom_range(255, 13));
            pick = $urandom_range(3);
            if (count > 8'd12) nackp = 100;
            else if (pick == 2) nackp = 5;
            else if (pick == 3) nackp = 30;
            else nackp = 0;
            run_xfer(cmd, 7'($urandom_range(127)), count, nackp, 1'b1);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        calm        <= 1'b0;
        hold_seq    <= 0;
        ticks_sent  = 0;
        nack_pct    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // address and ACK only, at the reset phase length
        run_xfer(CMD_WRITE, 7'h55, 8'd0, 0, 1'b0);

        // directed transactions at the fastest phase length
        write_phase_ticks(16'd1);
        run_xfer(CMD_WRITE, 7'h00, 8'd1, 0, 1'b1);     // commands while busy
        run_xfer(CMD_WRITE, 7'h2A, 8'hFF, 100, 1'b0);  // address NACK, longest length
        run_xfer(CMD_READ, 7'h7F, 8'd0, 0, 1'b0);      // zero-length read moves one byte
        run_xfer(CMD_READ, 7'h15, 8'd2, 0, 1'b1);
        run_xfer(CMD_READ, 7'h6B, 8'hFF, 100, 1'b0);   // read, address NACK
        run_xfer(CMD_UNUSED, 7'h33, 8'd2, 0, 1'b0);    // unused command at idle
        run_xfer(CMD_WRITE, 7'h01, 8'd4, 40, 1'b0);    // data NACK likely

        // random part; the result side holds off early on so the queue fills
        hold_seq <= hold_seq + 1;
        random_xfers(60);

        write_phase_ticks(16'd0);                      // zero acts as one tick
        random_xfers(40);

        // a stretch with no gaps and no stalls at all
        write_phase_ticks(16'd2);
        calm <= 1'b1;
        random_xfers(60);
        calm <= 1'b0;

        // longest phase length: start a write and leave it in its first phase
        write_phase_ticks(16'hFFFF);
        nack_pct = 0;
        send_tick(CMD_WRITE, 7'h4C, 8'd2);
        repeat (20) send_tick(CMD_NONE, 7'($urandom_range(127)), 8'($urandom_range(255)));

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_queue.sv
hdl/i2cm_engine.sv
hdl/i2c_master_transaction_unit.sv
test/i2cm_result_checker.sv
test/tb_top.sv
